@@ rtl/ork_pkg.sv @@
package ork_pkg;

   // Fixed word sizes of the channel fields
   localparam int DATA_W  = 32;
   localparam int STEP_W  = 31;
   localparam int COUNT_W = 16;
   localparam int WIDE_W  = 66;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 35;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 2'd2;

   // Register reset values and codes
   localparam logic [COUNT_W-1:0] STEP_LIMIT_RST = 16'd40;
   localparam logic METHOD_RK2 = 1'b0;
   localparam logic METHOD_RK4 = 1'b1;
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_STEP   = 1'b1;

   // Serial divide-by-three: 8 quotient bits per cycle over a 40-bit word
   localparam int DIV_BITS   = 40;
   localparam int DIV_STEP   = 8;
   localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam logic [2:0] DIV_BY = 3'd3;
   // dividend bias 3 * 2^31 keeps it non-negative; quotient carries 2^31 back
   localparam logic [ACC_W-1:0]  DIV_BIAS_IN  = 35'd6442450944;
   localparam logic [WIDE_W-1:0] DIV_BIAS_OUT = 66'd2147483648;

   // Slope evaluation points
   typedef enum logic [1:0] {
      PT_MID,
      PT_START,
      PT_END
   } pt_type;

   // Controller to datapath
   typedef struct packed {
      logic   load;
      logic   ld_arg;
      pt_type pt;
      logic   mul_en;
      logic   mul_sq;
      logic   slope_en;
      logic   acc_en;
      logic   acc_first;
      logic   div_init;
      logic   div_step;
      logic   update;
      logic   publish;
      logic   done;
   } ork_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic at_limit;
      logic rk4;
   } ork_stat_type;

   // Clamp a two's complement wide value to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (!v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1])) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1])) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/ork_intf.sv @@
interface ork_req_if import ork_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] x_in;
   logic signed [DATA_W-1:0] y_in;

   modport source (output valid, cmd, x_in, y_in, input ready);
   modport sink (input valid, cmd, x_in, y_in, output ready);
endinterface

interface ork_rsp_if import ork_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] x_out;
   logic signed [DATA_W-1:0] y_out;
   logic [COUNT_W-1:0]       step_index;
   logic                     done_res;

   modport source (output valid, x_out, y_out, step_index, done_res, input ready);
   modport sink (input valid, x_out, y_out, step_index, done_res, output ready);
endinterface

interface ork_csr_if import ork_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ode_runge_kutta_stepper.sv @@
// One item at a time: the next beat is taken once the result has been handed off.
// The shared 32x32 multiplier (two products per slope point) and the divide by
// three set the step time. Synchronous active-high reset clears the point and
// step count to zero and loads step 0.5, fourth-order, limit 40.
module ode_runge_kutta_stepper import ork_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   ork_req_if.sink   req_ch,
   ork_rsp_if.source rsp_ch,
   ork_csr_if.sink   csr_ch
);

   ork_cmd_type  cmd;
   ork_stat_type stat;

   // Configuration writes are always taken
   assign csr_ch.ready = 1'b1;

   ork_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ork_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .x_in       (req_ch.x_in),
      .y_in       (req_ch.y_in),
      .x_out      (rsp_ch.x_out),
      .y_out      (rsp_ch.y_out),
      .step_index (rsp_ch.step_index),
      .done_res   (rsp_ch.done_res)
   );

`ifndef SYNTH
   // Never overwrite a result beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result overwritten while stalled");

   // A result beat appears only after a publish
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.publish))
      else $error("result valid without publish");

   // No item is taken while a step is being computed
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.mul_en || cmd.update) |-> !req_ch.ready)
      else $error("input ready during computation");

   // A load updates state and never also runs a step update
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.update && !cmd.acc_en)
      else $error("load overlaps a step");
`endif

endmodule

@@ rtl/ork_dpath.sv @@
module ork_dpath import ork_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ork_cmd_type              cmd,
   output ork_stat_type             stat,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   input  logic signed [DATA_W-1:0] x_in,
   input  logic signed [DATA_W-1:0] y_in,
   output logic signed [DATA_W-1:0] x_out,
   output logic signed [DATA_W-1:0] y_out,
   output logic [COUNT_W-1:0]       step_index,
   output logic                     done_res
);

   localparam logic [WIDE_W-1:0] TWO_FIX  = 66'd2 << FRAC_BITS;
   localparam logic [STEP_W-1:0] STEP_RST = 31'd1 << (FRAC_BITS - 1);

   // Configuration
   logic [STEP_W-1:0]  step_size_ff;
   logic               method_ff;
   logic [COUNT_W-1:0] step_limit_ff;

   // Integration state
   logic signed [DATA_W-1:0] cur_x_ff;
   logic signed [DATA_W-1:0] cur_y_ff;
   logic [COUNT_W-1:0]       steps_ff;

   // Working registers
   logic signed [DATA_W-1:0] arg_ff;
   logic signed [DATA_W-1:0] f_ff;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DIV_BITS-1:0]      dv_ff;
   logic [1:0]               rem_ff;
   logic [DIV_BITS-1:0]      dv_in;
   logic [1:0]               rem_in;

   logic [WIDE_W-1:0]        x_ext;
   logic [WIDE_W-1:0]        y_ext;
   logic [WIDE_W-1:0]        h_ext;
   logic [WIDE_W-1:0]        hh_ext;
   logic signed [DATA_W-1:0] x_mid;
   logic signed [DATA_W-1:0] x_end;
   logic signed [DATA_W-1:0] pt_val;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [WIDE_W-1:0]        sq_ext;
   logic [WIDE_W-1:0]        x2_ext;
   logic signed [DATA_W-1:0] slope_val;
   logic signed [WIDE_W-1:0] pd_s;
   logic signed [DATA_W-1:0] incr_val;
   logic signed [ACC_W-1:0]  d_ext;
   logic signed [ACC_W-1:0]  half_acc;
   logic [WIDE_W-1:0]        acc_ext;
   logic [WIDE_W-1:0]        quo_ext;
   logic signed [DATA_W-1:0] y_rk2;
   logic signed [DATA_W-1:0] y_rk4;

   assign x_ext  = {{(WIDE_W-DATA_W){cur_x_ff[DATA_W-1]}}, cur_x_ff};
   assign y_ext  = {{(WIDE_W-DATA_W){cur_y_ff[DATA_W-1]}}, cur_y_ff};
   assign h_ext  = {{(WIDE_W-STEP_W){1'b0}}, step_size_ff};
   assign hh_ext = {{(WIDE_W-STEP_W+1){1'b0}}, step_size_ff[STEP_W-1:1]};

   // Abscissa at half and full step
   assign x_mid = sat32(x_ext + hh_ext);
   assign x_end = sat32(x_ext + h_ext);

   always_comb begin
      case (cmd.pt)
         PT_MID:   pt_val = x_mid;
         PT_START: pt_val = cur_x_ff;
         PT_END:   pt_val = x_end;
         default:  pt_val = cur_x_ff;
      endcase
   end

   // Shared multiplier: x*x or h*f
   assign mul_a = cmd.mul_sq ? arg_ff : {1'b0, step_size_ff};
   assign mul_b = cmd.mul_sq ? arg_ff : f_ff;
   assign prod  = mul_a * mul_b;

   // Slope from the registered square
   assign sq_ext    = {2'b00, p_ff} >> (FRAC_BITS + 1);
   assign x2_ext    = {{(WIDE_W-DATA_W-1){arg_ff[DATA_W-1]}}, arg_ff, 1'b0};
   assign slope_val = sat32(sq_ext - x2_ext + TWO_FIX);

   // Increment from the registered h*f, floor shift
   assign pd_s     = {{(WIDE_W-PROD_W){p_ff[PROD_W-1]}}, p_ff};
   assign incr_val = sat32(pd_s >>> FRAC_BITS);
   assign d_ext    = {{(ACC_W-DATA_W){incr_val[DATA_W-1]}}, incr_val};
   assign half_acc = acc_ff >>> 1;

   // Eight quotient bits of the divide by three
   always_comb begin
      logic [2:0] r3;
      logic       qb;
      dv_in  = dv_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         r3 = {rem_in, dv_in[DIV_BITS-1]};
         qb = (r3 >= DIV_BY);
         if (qb) begin
            r3 = r3 - DIV_BY;
         end
         dv_in  = {dv_in[DIV_BITS-2:0], qb};
         rem_in = r3[1:0];
      end
   end

   // New ordinate for each method
   assign acc_ext = {{(WIDE_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff};
   assign quo_ext = {{(WIDE_W-DIV_BITS){1'b0}}, dv_ff};
   assign y_rk2   = sat32(y_ext + acc_ext);
   assign y_rk4   = sat32(y_ext + quo_ext - DIV_BIAS_OUT);

   assign stat.at_limit = (steps_ff >= step_limit_ff);
   assign stat.rk4      = method_ff;

   // Configuration writes and integration state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff  <= STEP_RST;
         method_ff     <= METHOD_RK4;
         step_limit_ff <= STEP_LIMIT_RST;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         steps_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_SIZE:  step_size_ff  <= csr_data[STEP_W-1:0];
               CSR_METHOD:     method_ff     <= csr_data[0];
               CSR_STEP_LIMIT: step_limit_ff <= csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            cur_x_ff <= x_in;
            cur_y_ff <= y_in;
            steps_ff <= '0;
         end else if (cmd.update) begin
            cur_x_ff <= x_end;
            cur_y_ff <= method_ff ? y_rk4 : y_rk2;
            steps_ff <= steps_ff + 16'd1;
         end
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.ld_arg) begin
         arg_ff <= pt_val;
      end
      if (cmd.mul_en) begin
         p_ff <= prod;
      end
      if (cmd.slope_en) begin
         f_ff <= slope_val;
      end
      if (cmd.acc_en) begin
         if (cmd.acc_first) begin
            acc_ff <= method_ff ? (d_ext <<< 2) : d_ext;
         end else begin
            acc_ff <= acc_ff + d_ext;
         end
      end
      if (cmd.div_init) begin
         dv_ff  <= {{(DIV_BITS-ACC_W){1'b0}}, half_acc + DIV_BIAS_IN};
         rem_ff <= 2'd0;
      end else if (cmd.div_step) begin
         dv_ff  <= dv_in;
         rem_ff <= rem_in;
      end
      if (cmd.publish) begin
         x_out      <= cur_x_ff;
         y_out      <= cur_y_ff;
         step_index <= steps_ff;
         done_res   <= cmd.done;
      end
   end

endmodule

@@ rtl/ork_ctrl.sv @@
module ork_ctrl import ork_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ork_stat_type stat,
   output ork_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARG,
      ST_SQ,
      ST_SLOPE,
      ST_MULH,
      ST_ACC,
      ST_DINIT,
      ST_DIV,
      ST_UPD,
      ST_OUT
   } state_type;

   state_type            state_ff;
   pt_type               pt_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic                 rsp_valid_ff;
   logic                 last_pt;

   assign last_pt   = !stat.rk4 || (pt_ff == PT_END);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the state
   always_comb begin
      cmd    = '0;
      cmd.pt = PT_MID;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid && (req_cmd == CMD_LOAD);
         end
         ST_ARG: begin
            cmd.ld_arg = 1'b1;
         end
         ST_SQ: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sq = 1'b1;
         end
         ST_SLOPE: begin
            cmd.slope_en = 1'b1;
         end
         ST_MULH: begin
            cmd.mul_en = 1'b1;
         end
         ST_ACC: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_first = (pt_ff == PT_MID);
            // load the next point while the increment is summed
            cmd.ld_arg    = 1'b1;
            cmd.pt        = (pt_ff == PT_MID) ? PT_START : PT_END;
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
         end
         ST_OUT: begin
            cmd.publish = !rsp_valid_ff || rsp_ready;
            cmd.done    = done_ff;
         end
         default: ;
      endcase
   end

   // Sequence one item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pt_ff        <= PT_MID;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pt_ff <= PT_MID;
                  if (req_cmd == CMD_LOAD) begin
                     done_ff  <= 1'b0;
                     state_ff <= ST_OUT;
                  end else if (stat.at_limit) begin
                     done_ff  <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     done_ff  <= 1'b0;
                     state_ff <= ST_ARG;
                  end
               end
            end
            ST_ARG:   state_ff <= ST_SQ;
            ST_SQ:    state_ff <= ST_SLOPE;
            ST_SLOPE: state_ff <= ST_MULH;
            ST_MULH:  state_ff <= ST_ACC;
            ST_ACC: begin
               if (last_pt) begin
                  state_ff <= stat.rk4 ? ST_DINIT : ST_UPD;
               end else begin
                  pt_ff    <= (pt_ff == PT_MID) ? PT_START : PT_END;
                  state_ff <= ST_SQ;
               end
            end
            ST_DINIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                  state_ff <= ST_UPD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_UPD: state_ff <= ST_OUT;
            ST_OUT: begin
               if (cmd.publish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ tb/tb_ode_runge_kutta_stepper.sv @@
`timescale 1ns / 100ps

module tb_ode_runge_kutta_stepper;
   import ork_pkg::*;

   localparam int FRAC           = 16;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 115;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;

   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] X_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] X_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [COUNT_W-1:0]       idx;
      logic                     done;
   } point_beat_t;

   typedef struct {
      logic                     is_csr;
      logic [CSR_IDX_W-1:0]     index;
      logic [DATA_W-1:0]        data;
      logic                     cmd;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic                     typed;
      point_beat_t              want;
   } probe_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ork_req_if req_bus ();
   ork_rsp_if rsp_bus ();
   ork_csr_if csr_bus ();

   ode_runge_kutta_stepper #(.FRAC_BITS(FRAC)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #5 clock = ~clock;

   // Mirror of the block's registers and current point
   logic [STEP_W-1:0]        cfg_step;
   logic                     cfg_method;
   logic [COUNT_W-1:0]       cfg_limit;
   logic signed [DATA_W-1:0] pt_x;
   logic signed [DATA_W-1:0] pt_y;
   logic [COUNT_W-1:0]       pt_steps;

   point_beat_t pending_points[$];
   probe_row_t  probe_rows[$];

   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          steady = 1'b0;
   bit          use_typed = 1'b0;
   point_beat_t typed_beat;

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [DATA_W-1:0] clamp_word(input logic signed [63:0] v);
      if (v > SAT_HI) begin
         return X_MAX;
      end else if (v < SAT_LO) begin
         return X_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   // x*x/2 - 2x + 2, ignoring y
   function automatic logic signed [63:0] slope_at(input logic signed [63:0] xw);
      logic signed [63:0] sq;
      sq = (xw * xw) >>> (FRAC + 1);
      return clamp_word(sq - 2 * xw + (64'sd2 <<< FRAC));
   endfunction

   function automatic logic signed [63:0] increment(input logic signed [63:0] h,
                                                    input logic signed [63:0] fv);
      return clamp_word((h * fv) >>> FRAC);
   endfunction

   function automatic logic signed [63:0] floor_div6(input logic signed [63:0] s);
      logic signed [63:0] q;
      q = s / 64'sd6;
      if ((s % 64'sd6) != 0 && s < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   // Apply one item to the mirrored point and return the beat it produces
   function automatic point_beat_t next_point(input logic cmd,
                                              input logic signed [DATA_W-1:0] x_in,
                                              input logic signed [DATA_W-1:0] y_in);
      point_beat_t        r;
      logic signed [63:0] h, xm, xe, dm, d1, d4, acc;
      r.done = 1'b0;
      if (cmd == CMD_LOAD) begin
         pt_x     = x_in;
         pt_y     = y_in;
         pt_steps = '0;
      end else if (pt_steps >= cfg_limit) begin
         r.done = 1'b1;
      end else begin
         h  = {33'b0, cfg_step};
         xm = clamp_word(pt_x + (h >>> 1));
         xe = clamp_word(pt_x + h);
         dm = increment(h, slope_at(xm));
         if (cfg_method == METHOD_RK2) begin
            pt_y = clamp_word(pt_y + dm);
         end else begin
            d1   = increment(h, slope_at(pt_x));
            d4   = increment(h, slope_at(xe));
            acc  = d1 + 4 * dm + d4;
            pt_y = clamp_word(pt_y + floor_div6(acc));
         end
         pt_x     = xe[DATA_W-1:0];
         pt_steps = pt_steps + 1'b1;
      end
      r.x   = pt_x;
      r.y   = pt_y;
      r.idx = pt_steps;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int pick_gap();
      if (steady || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 18);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return X_MAX;
         3:       return X_MIN;
         default: return int'($urandom_range(0, 40 * 65536)) - 20 * 65536;
      endcase
   endfunction

   // Offer one request beat, hold it until taken, then record what it should produce
   task automatic send_point(input logic cmd, input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y);
      int          gap;
      point_beat_t r;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.x_in  <= x;
      req_bus.y_in  <= y;
      do @(posedge clock); while (!req_bus.ready);
      r = next_point(cmd, x, y);
      pending_points.push_back(use_typed ? typed_beat : r);
   endtask

   // Drop the request and hold until every expected beat has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         CSR_STEP_SIZE:  cfg_step   = data[STEP_W-1:0];
         CSR_METHOD:     cfg_method = data[0];
         CSR_STEP_LIMIT: cfg_limit  = data[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_point_beat();
      point_beat_t want;
      if (pending_points.size() == 0) begin
         report_mismatch("result beat with nothing expected");
      end else begin
         want = pending_points.pop_front();
         if (rsp_bus.x_out !== want.x)
            report_mismatch($sformatf("x_out %h, want %h", rsp_bus.x_out, want.x));
         if (rsp_bus.y_out !== want.y)
            report_mismatch($sformatf("y_out %h, want %h", rsp_bus.y_out, want.y));
         if (rsp_bus.step_index !== want.idx)
            report_mismatch($sformatf("step_index %0d, want %0d", rsp_bus.step_index,
                                      want.idx));
         if (rsp_bus.done_res !== want.done)
            report_mismatch($sformatf("done_res %b, want %b", rsp_bus.done_res, want.done));
      end
   endtask

   // Check result beats and stall the result side in random bursts
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         check_point_beat();
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= $urandom_range(0, 17);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Count cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] index,
                                   input logic [DATA_W-1:0] data);
      probe_row_t row;
      row        = '{default: '0};
      row.is_csr = 1'b1;
      row.index  = index;
      row.data   = data;
      probe_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic cmd, input logic signed [DATA_W-1:0] x,
                                    input logic signed [DATA_W-1:0] y);
      probe_row_t row;
      row     = '{default: '0};
      row.cmd = cmd;
      row.x   = x;
      row.y   = y;
      probe_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic cmd, input logic signed [DATA_W-1:0] x,
                                       input logic signed [DATA_W-1:0] y,
                                       input logic signed [DATA_W-1:0] wx,
                                       input logic signed [DATA_W-1:0] wy,
                                       input logic [COUNT_W-1:0] widx, input logic wdone);
      probe_row_t row;
      row       = '{default: '0};
      row.cmd   = cmd;
      row.x     = x;
      row.y     = y;
      row.typed = 1'b1;
      row.want  = '{x: wx, y: wy, idx: widx, done: wdone};
      probe_rows.push_back(row);
   endfunction

   // Directed table: extremes, both methods, limit and saturation cases
   function automatic void build_probe_rows();
      // step straight after reset with the default registers
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      // load echoes, then x pinned at the top of the range
      add_checked(CMD_LOAD, X_MAX, X_MIN, X_MAX, X_MIN, 16'd0, 1'b0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_checked(CMD_LOAD, X_MIN, X_MAX, X_MIN, X_MAX, 16'd0, 1'b0);
      add_item(CMD_STEP, X_MAX, X_MIN);
      add_item(CMD_STEP, X_MIN, X_MAX);
      // step toward zero from negative x
      add_checked(CMD_LOAD, -32'sd163840, 32'sd0, -32'sd163840, 32'sd0, 16'd0, 1'b0);
      repeat (4) add_item(CMD_STEP, -32'sd1, -32'sd1);
      // midpoint method, upper data bits masked
      add_csr(CSR_METHOD, 32'hFFFF_FFFE);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      // zero limit holds the loaded point
      add_csr(CSR_STEP_LIMIT, 32'h0000_0000);
      add_checked(CMD_LOAD, 32'sd327680, 32'sd458752, 32'sd327680, 32'sd458752, 16'd0, 1'b0);
      add_checked(CMD_STEP, 32'sd0, 32'sd0, 32'sd327680, 32'sd458752, 16'd0, 1'b1);
      add_csr(CSR_STEP_LIMIT, 32'hABCD_0002);
      // zero step, then the largest step
      add_csr(CSR_STEP_SIZE, 32'h0000_0000);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_csr(CSR_STEP_SIZE, 32'hFFFF_FFFF);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      // limit lowered below the steps already taken
      add_csr(CSR_STEP_LIMIT, 32'h0000_0001);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      // unknown index is ignored
      add_csr(CSR_UNUSED, 32'h1234_5678);
      add_csr(CSR_METHOD, 32'hFFFF_FFFF);
      add_csr(CSR_STEP_SIZE, 32'h8000_0001);
      add_csr(CSR_STEP_LIMIT, 32'hFFFF_FFFF);
      add_checked(CMD_LOAD, 32'sd0, 32'sh7FFF_0000, 32'sd0, 32'sh7FFF_0000, 16'd0, 1'b0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
      add_checked(CMD_LOAD, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'd0, 1'b0);
      add_item(CMD_STEP, 32'sd0, 32'sd0);
   endfunction

   // One random phase: fresh registers, then mostly load-and-run sequences
   task automatic run_phase(input int quota);
      int                 made;
      int                 run_len;
      logic [STEP_W-1:0]  h_val;
      logic [COUNT_W-1:0] lim_val;
      logic [DATA_W-1:0]  word;
      made = 0;
      wait_drained();
      case ($urandom_range(0, 9))
         0:       h_val = '0;
         1:       h_val = '1;
         2:       h_val = $urandom;
         default: h_val = $urandom_range(1, 1 << 17);
      endcase
      word         = $urandom;
      word[30:0]   = h_val;
      write_csr(CSR_STEP_SIZE, word);
      write_csr(CSR_METHOD, $urandom);
      case ($urandom_range(0, 7))
         0:       lim_val = '0;
         1:       lim_val = '1;
         default: lim_val = $urandom_range(1, 60);
      endcase
      word       = $urandom;
      word[15:0] = lim_val;
      write_csr(CSR_STEP_LIMIT, word);
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_UNUSED, $urandom);
      end
      while (made < quota) begin
         if ($urandom_range(0, 6) != 0) begin
            send_point(CMD_LOAD, random_coord(), random_coord());
            made++;
            run_len = $urandom_range(1, (lim_val > 16'd60) ? 63 : int'(lim_val) + 3);
            repeat (run_len) begin
               send_point(CMD_STEP, random_coord(), random_coord());
               made++;
            end
         end else begin
            send_point($urandom_range(0, 1), random_coord(), random_coord());
            made++;
         end
         // pause the sender until the block has drained
         if ($urandom_range(0, 19) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      probe_row_t row;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_LOAD;
      req_bus.x_in  = '0;
      req_bus.y_in  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_STEP_SIZE;
      csr_bus.data  = '0;
      cfg_step      = STEP_W'(1) << (FRAC - 1);
      cfg_method    = METHOD_RK4;
      cfg_limit     = STEP_LIMIT_RST;
      pt_x          = '0;
      pt_y          = '0;
      pt_steps      = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      build_probe_rows();
      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         if (row.is_csr) begin
            wait_drained();
            write_csr(row.index, row.data);
         end else begin
            use_typed  = row.typed;
            typed_beat = row.want;
            send_point(row.cmd, row.x, row.y);
         end
      end
      use_typed = 1'b0;

      // random phases, the last ones without idling
      for (int p = 0; p < PHASES; p++) begin
         if (p >= PHASES - 2) begin
            steady = 1'b1;
         end
         run_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_points.size() != 0) begin
         report_mismatch($sformatf("%0d result beats never arrived", pending_points.size()));
      end
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ork_pkg.sv
rtl/ork_intf.sv
rtl/ork_dpath.sv
rtl/ork_ctrl.sv
rtl/ode_runge_kutta_stepper.sv
tb/tb_ode_runge_kutta_stepper.sv
